// ----- src/touch_dimmer_controller_top_macros.svh -----
// ---------------------------------------------------------------------------
// Assertion macros for the touch dimmer controller checker
// ---------------------------------------------------------------------------
`ifndef TOUCH_DIMMER_CONTROLLER_TOP_MACROS_SVH
`define TOUCH_DIMMER_CONTROLLER_TOP_MACROS_SVH

// same-cycle implication, disabled in reset
`define TDC_ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled in reset
`define TDC_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- src/tdc_pkg.sv -----
// ---------------------------------------------------------------------------
// tdc_pkg
// Shared types and constants of the touch dimmer controller.
// ---------------------------------------------------------------------------
`default_nettype none

package tdc_pkg;

    localparam int LEVEL_BITS = 12;
    localparam int GAP_BITS   = 16;

    // field and register widths
    localparam int OUT_LEVEL_BITS = 12;
    localparam int LONG_GAP_BITS  = 16;
    localparam int STEP_BITS      = 8;
    localparam int LIMIT_BITS     = 12;
    localparam int CFG_IDX_BITS   = 3;
    localparam int CFG_DATA_BITS  = 16;

    // compare widths, wide enough for both operands (and a carry for levels)
    localparam int GAP_CMP_BITS = (GAP_BITS > LONG_GAP_BITS) ? GAP_BITS : LONG_GAP_BITS;
    localparam int LVL_CMP_BITS = ((LEVEL_BITS > LIMIT_BITS) ? LEVEL_BITS : LIMIT_BITS) + 1;

    localparam logic [LEVEL_BITS-1:0] LEVEL_MAX   = {LEVEL_BITS{1'b1}};
    localparam logic [LEVEL_BITS-1:0] LEVEL_RESET = LEVEL_BITS'(1000);

    localparam logic [LONG_GAP_BITS-1:0] LONG_GAP_RESET    = 16'd50;
    localparam logic [STEP_BITS-1:0]     DIM_STEP_RESET    = 8'd10;
    localparam logic [LIMIT_BITS-1:0]    UPPER_LIMIT_RESET = 12'd3990;
    localparam logic [LIMIT_BITS-1:0]    RAMP_MAX_RESET    = 12'd4095;

    // configuration register indexes
    localparam logic [CFG_IDX_BITS-1:0] REG_LONG_GAP    = 3'd0;
    localparam logic [CFG_IDX_BITS-1:0] REG_DIM_STEP    = 3'd1;
    localparam logic [CFG_IDX_BITS-1:0] REG_UPPER_LIMIT = 3'd2;
    localparam logic [CFG_IDX_BITS-1:0] REG_RAMP_MAX    = 3'd3;

    // item kinds
    localparam logic CMD_TICK = 1'b0;
    localparam logic CMD_KEY  = 1'b1;

    typedef enum logic [1:0] {
        MODE_OFF  = 2'd0,
        MODE_ON   = 2'd1,
        MODE_RAMP = 2'd2
    } mode_t;

endpackage

`default_nettype wire

// ----- src/tdc_if.sv -----
// ---------------------------------------------------------------------------
// tdc_event_if / tdc_result_if
// Valid/ready channels for key and tick items and for dimmer results.
// ---------------------------------------------------------------------------
`default_nettype none

interface tdc_event_if;
    logic valid;
    logic ready;
    logic command;
    logic key_pressed;
    logic key_released;
    logic key_long_press;

    modport source (
        output valid, command, key_pressed, key_released, key_long_press,
        input  ready
    );
    modport sink (
        input  valid, command, key_pressed, key_released, key_long_press,
        output ready
    );
endinterface

interface tdc_result_if;
    logic                                valid;
    logic                                ready;
    logic                                light_on;
    logic [tdc_pkg::OUT_LEVEL_BITS-1:0] level;
    logic                                level_written;
    logic                                ramping;

    modport source (
        output valid, light_on, level, level_written, ramping,
        input  ready
    );
    modport sink (
        input  valid, light_on, level, level_written, ramping,
        output ready
    );
endinterface

`default_nettype wire

// ----- src/touch_dimmer_controller_top.sv -----
// ---------------------------------------------------------------------------
// touch_dimmer_controller_top
// One-key LED dimmer: on/off toggle, long-press dimming, slow wake-up ramp.
// ---------------------------------------------------------------------------
// Takes one item per clock and gives one result per item. An item is held in
// an input register, and the mode/level/direction/gap update is a single pass
// of compare-and-add logic from it into the result register, so a result
// passes through the input register and then the result register. A full
// rate of one item per cycle is kept as long as the result side is ready.
// The result register stalls the input register, which in turn drops event
// ready.
`default_nettype none

module touch_dimmer_controller_top (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    tdc_event_if.sink                              event_ch,
    tdc_result_if.source                           result_ch,
    input  wire logic                              cfg_we,
    input  wire logic [tdc_pkg::CFG_IDX_BITS-1:0]  cfg_index,
    input  wire logic [tdc_pkg::CFG_DATA_BITS-1:0] cfg_data
);

    // configuration
    logic [tdc_pkg::LONG_GAP_BITS-1:0] long_gap_reg;
    logic [tdc_pkg::STEP_BITS-1:0]     dim_step_reg;
    logic [tdc_pkg::LIMIT_BITS-1:0]    upper_limit_reg;
    logic [tdc_pkg::LIMIT_BITS-1:0]    ramp_max_reg;

    // dimmer state
    tdc_pkg::mode_t                    mode_reg, mode_next;
    logic [tdc_pkg::LEVEL_BITS-1:0]    bright_reg, bright_next;
    logic                              dim_down_reg, dim_down_next;
    logic [tdc_pkg::GAP_BITS-1:0]      gap_reg, gap_next;
    logic                              written_next;

    // input stage
    logic s1_valid_reg;
    logic s1_command_reg;
    logic s1_pressed_reg;
    logic s1_released_reg;
    logic s1_long_reg;

    // result stage
    logic                                 out_valid_reg;
    logic                                 out_light_on_reg, out_light_on_next;
    logic [tdc_pkg::OUT_LEVEL_BITS-1:0]   out_level_reg, out_level_next;
    logic                                 out_written_reg;
    logic                                 out_ramping_reg, out_ramping_next;

    logic out_free;
    logic advance;
    logic accept;

    logic [tdc_pkg::LVL_CMP_BITS-1:0] sum_wide;

    assign out_free       = !out_valid_reg || result_ch.ready;
    assign advance        = s1_valid_reg && out_free;
    assign event_ch.ready = !s1_valid_reg || out_free;
    assign accept         = event_ch.valid && event_ch.ready;

    assign sum_wide = tdc_pkg::LVL_CMP_BITS'(bright_reg)
                    + tdc_pkg::LVL_CMP_BITS'(dim_step_reg);

    // configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            long_gap_reg    <= tdc_pkg::LONG_GAP_RESET;
            dim_step_reg    <= tdc_pkg::DIM_STEP_RESET;
            upper_limit_reg <= tdc_pkg::UPPER_LIMIT_RESET;
            ramp_max_reg    <= tdc_pkg::RAMP_MAX_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                tdc_pkg::REG_LONG_GAP:
                    long_gap_reg <= cfg_data[tdc_pkg::LONG_GAP_BITS-1:0];
                tdc_pkg::REG_DIM_STEP:
                    dim_step_reg <= cfg_data[tdc_pkg::STEP_BITS-1:0];
                tdc_pkg::REG_UPPER_LIMIT:
                    upper_limit_reg <= cfg_data[tdc_pkg::LIMIT_BITS-1:0];
                tdc_pkg::REG_RAMP_MAX:
                    ramp_max_reg <= cfg_data[tdc_pkg::LIMIT_BITS-1:0];
                default: ;
            endcase
        end
    end

    // next state: a tick, or a key item with pressed, released, long press in that order
    always_comb
    begin
        mode_next     = mode_reg;
        bright_next   = bright_reg;
        dim_down_next = dim_down_reg;
        gap_next      = gap_reg;
        written_next  = 1'b0;

        if (s1_command_reg == tdc_pkg::CMD_TICK)
        begin
            if (gap_reg != {tdc_pkg::GAP_BITS{1'b1}})
                gap_next = gap_reg + 1'b1;
            if (mode_reg == tdc_pkg::MODE_RAMP)
            begin
                if ((tdc_pkg::LVL_CMP_BITS'(bright_reg) < tdc_pkg::LVL_CMP_BITS'(ramp_max_reg))
                    && (bright_reg != tdc_pkg::LEVEL_MAX))
                    bright_next = bright_reg + 1'b1;
                written_next = 1'b1;
            end
        end
        else
        begin
            if (s1_pressed_reg)
            begin
                if (mode_reg == tdc_pkg::MODE_ON)
                    mode_next = tdc_pkg::MODE_OFF;
                else
                begin
                    mode_next    = tdc_pkg::MODE_ON;
                    written_next = 1'b1;
                end
            end
            if (s1_released_reg)
                dim_down_next = !dim_down_reg;
            if (s1_long_reg)
            begin
                case (mode_next)
                    tdc_pkg::MODE_ON:
                    begin
                        if (tdc_pkg::GAP_CMP_BITS'(gap_reg) >
                            tdc_pkg::GAP_CMP_BITS'(long_gap_reg))
                            dim_down_next = 1'b1;
                        gap_next = '0;
                        if (dim_down_next)
                        begin
                            if (tdc_pkg::LVL_CMP_BITS'(bright_reg) >=
                                tdc_pkg::LVL_CMP_BITS'(dim_step_reg))
                                bright_next = bright_reg
                                            - tdc_pkg::LEVEL_BITS'(dim_step_reg);
                        end
                        else if (tdc_pkg::LVL_CMP_BITS'(bright_reg) <
                                 tdc_pkg::LVL_CMP_BITS'(upper_limit_reg))
                        begin
                            if (sum_wide > tdc_pkg::LVL_CMP_BITS'(tdc_pkg::LEVEL_MAX))
                                bright_next = tdc_pkg::LEVEL_MAX;
                            else
                                bright_next = sum_wide[tdc_pkg::LEVEL_BITS-1:0];
                        end
                        written_next = 1'b1;
                    end
                    tdc_pkg::MODE_OFF:
                    begin
                        bright_next  = '0;
                        mode_next    = tdc_pkg::MODE_RAMP;
                        written_next = 1'b1;
                    end
                    default: ;
                endcase
            end
        end
    end

    // result fields from the updated state
    always_comb
    begin
        out_light_on_next = (mode_next == tdc_pkg::MODE_ON) ||
                            (mode_next == tdc_pkg::MODE_RAMP);
        out_ramping_next  = (mode_next == tdc_pkg::MODE_RAMP);
        out_level_next    = tdc_pkg::OUT_LEVEL_BITS'(bright_next);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg      <= tdc_pkg::MODE_OFF;
            bright_reg    <= tdc_pkg::LEVEL_RESET;
            dim_down_reg  <= 1'b1;
            gap_reg       <= '0;
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (accept)
                s1_valid_reg <= 1'b1;
            else if (advance)
                s1_valid_reg <= 1'b0;

            if (advance)
            begin
                mode_reg      <= mode_next;
                bright_reg    <= bright_next;
                dim_down_reg  <= dim_down_next;
                gap_reg       <= gap_next;
                out_valid_reg <= 1'b1;
            end
            else if (result_ch.ready)
                out_valid_reg <= 1'b0;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_command_reg  <= event_ch.command;
            s1_pressed_reg  <= event_ch.key_pressed;
            s1_released_reg <= event_ch.key_released;
            s1_long_reg     <= event_ch.key_long_press;
        end
        if (advance)
        begin
            out_light_on_reg <= out_light_on_next;
            out_level_reg    <= out_level_next;
            out_written_reg  <= written_next;
            out_ramping_reg  <= out_ramping_next;
        end
    end

    assign result_ch.valid         = out_valid_reg;
    assign result_ch.light_on      = out_light_on_reg;
    assign result_ch.level         = out_level_reg;
    assign result_ch.level_written = out_written_reg;
    assign result_ch.ramping       = out_ramping_reg;

endmodule

`default_nettype wire

// ----- src/tdc_checker.sv -----
// ---------------------------------------------------------------------------
// tdc_checker
// Port-level checks of the touch dimmer controller, bound to the top level.
// ---------------------------------------------------------------------------
`default_nettype none

`include "touch_dimmer_controller_top_macros.svh"

module tdc_checker (
    input wire logic                               clk,
    input wire logic                               rst_n,
    input wire logic                               res_valid,
    input wire logic                               res_ready,
    input wire logic                               res_light_on,
    input wire logic [tdc_pkg::OUT_LEVEL_BITS-1:0] res_level,
    input wire logic                               res_written,
    input wire logic                               res_ramping
);

    // a stalled result holds its valid, level and ramping fields
    `TDC_ASSERT_NEXT(a_res_hold, clk, rst_n, res_valid && !res_ready, res_valid && $stable(res_level) && $stable(res_ramping), "result changed while stalled")

    // ramp mode always drives the LED
    `TDC_ASSERT_IMPLY(a_ramp_lit, clk, rst_n, res_valid && res_ramping, res_light_on, "ramping without light on")

    // an item that leaves the light off never writes the driver
    `TDC_ASSERT_IMPLY(a_off_no_write, clk, rst_n, res_valid && !res_light_on, !res_written, "driver written while off")

endmodule

bind touch_dimmer_controller_top tdc_checker u_tdc_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .res_valid    (result_ch.valid),
    .res_ready    (result_ch.ready),
    .res_light_on (result_ch.light_on),
    .res_level    (result_ch.level),
    .res_written  (result_ch.level_written),
    .res_ramping  (result_ch.ramping)
);

`default_nettype wire

// ----- dv/touch_dimmer_controller_top_tb.sv -----
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// touch_dimmer_controller_top_tb
// Self-checking bench for the touch dimmer: drives tick and key items over the
// event channel, predicts mode, level and direction per item, and compares
// every result in order. Random idling on both sides, one long result stall.
// ---------------------------------------------------------------------------
module touch_dimmer_controller_top_tb;

    localparam int unsigned CYCLE_LIMIT = 2_000_000;
    localparam int          DRAIN_CYCLES = 4;
    localparam int          HOLD_CYCLES = 300;
    localparam int          MAX_PRINTS = 20;

    typedef struct packed {
        logic                               light_on;
        logic [tdc_pkg::OUT_LEVEL_BITS-1:0] level;
        logic                               level_written;
        logic                               ramping;
    } dimmer_result_t;

    class dimmer_scoreboard;
        // predicted block state and registers
        tdc_pkg::mode_t                    mode;
        logic [tdc_pkg::LEVEL_BITS-1:0]    brightness;
        bit                                dim_down;
        logic [tdc_pkg::GAP_BITS-1:0]      gap_ticks;
        logic [tdc_pkg::LONG_GAP_BITS-1:0] long_gap;
        logic [tdc_pkg::STEP_BITS-1:0]     dim_step;
        logic [tdc_pkg::LIMIT_BITS-1:0]    upper_limit;
        logic [tdc_pkg::LIMIT_BITS-1:0]    ramp_max;

        dimmer_result_t predicted_q[$];
        int n_errors;
        int n_items;
        int n_results;
        int n_ramp_ticks;
        int n_steps;
        int n_forced;

        function new();
            mode = tdc_pkg::MODE_OFF;
            brightness = tdc_pkg::LEVEL_RESET;
            dim_down = 1'b1;
            gap_ticks = '0;
            long_gap = tdc_pkg::LONG_GAP_RESET;
            dim_step = tdc_pkg::DIM_STEP_RESET;
            upper_limit = tdc_pkg::UPPER_LIMIT_RESET;
            ramp_max = tdc_pkg::RAMP_MAX_RESET;
            n_errors = 0;
            n_items = 0;
            n_results = 0;
            n_ramp_ticks = 0;
            n_steps = 0;
            n_forced = 0;
        endfunction

        function void set_reg(logic [tdc_pkg::CFG_IDX_BITS-1:0] idx,
                              logic [tdc_pkg::CFG_DATA_BITS-1:0] data);
            case (idx)
                tdc_pkg::REG_LONG_GAP:    long_gap = data[tdc_pkg::LONG_GAP_BITS-1:0];
                tdc_pkg::REG_DIM_STEP:    dim_step = data[tdc_pkg::STEP_BITS-1:0];
                tdc_pkg::REG_UPPER_LIMIT: upper_limit = data[tdc_pkg::LIMIT_BITS-1:0];
                tdc_pkg::REG_RAMP_MAX:    ramp_max = data[tdc_pkg::LIMIT_BITS-1:0];
                default: ;
            endcase
        endfunction

        function int pending();
            return predicted_q.size();
        endfunction

        // advance the dimmer by one accepted item and queue its result
        function void predict_item(logic cmd, logic kp, logic kr, logic kl);
            bit                           written;
            logic [tdc_pkg::LEVEL_BITS:0] sum;
            dimmer_result_t               res;
            written = 1'b0;
            n_items++;
            if (cmd == tdc_pkg::CMD_TICK)
            begin
                if (gap_ticks != {tdc_pkg::GAP_BITS{1'b1}})
                    gap_ticks = gap_ticks + 1'b1;
                if (mode == tdc_pkg::MODE_RAMP)
                begin
                    n_ramp_ticks++;
                    if (brightness < ramp_max && brightness < tdc_pkg::LEVEL_MAX)
                        brightness = brightness + 1'b1;
                    written = 1'b1;
                end
            end
            else
            begin
                if (kp)
                begin
                    if (mode == tdc_pkg::MODE_ON)
                        mode = tdc_pkg::MODE_OFF;
                    else
                    begin
                        mode = tdc_pkg::MODE_ON;
                        written = 1'b1;
                    end
                end
                if (kr)
                    dim_down = !dim_down;
                if (kl)
                begin
                    if (mode == tdc_pkg::MODE_ON)
                    begin
                        n_steps++;
                        if (gap_ticks > long_gap)
                        begin
                            dim_down = 1'b1;
                            n_forced++;
                        end
                        gap_ticks = '0;
                        if (dim_down)
                        begin
                            if (brightness >= dim_step)
                                brightness = brightness - dim_step;
                        end
                        else if (brightness < upper_limit)
                        begin
                            sum = {1'b0, brightness} + dim_step;
                            brightness = (sum > tdc_pkg::LEVEL_MAX) ? tdc_pkg::LEVEL_MAX
                                                                    : sum[tdc_pkg::LEVEL_BITS-1:0];
                        end
                        written = 1'b1;
                    end
                    else if (mode == tdc_pkg::MODE_OFF)
                    begin
                        brightness = '0;
                        mode = tdc_pkg::MODE_RAMP;
                        written = 1'b1;
                    end
                end
            end
            res.light_on = (mode == tdc_pkg::MODE_ON || mode == tdc_pkg::MODE_RAMP);
            res.level = brightness[tdc_pkg::OUT_LEVEL_BITS-1:0];
            res.level_written = written;
            res.ramping = (mode == tdc_pkg::MODE_RAMP);
            predicted_q.push_back(res);
        endfunction

        task report_mismatch(string what, int unsigned got, int unsigned want);
            n_errors++;
            if (n_errors <= MAX_PRINTS)
                $display("%0t: mismatch on %s: got %0d, expected %0d (result %0d)",
                         $realtime, what, got, want, n_results);
        endtask

        task check_result(dimmer_result_t got);
            dimmer_result_t want;
            if (predicted_q.size() == 0)
            begin
                report_mismatch("unexpected result", 1, 0);
                return;
            end
            want = predicted_q.pop_front();
            n_results++;
            if (got.light_on !== want.light_on)
                report_mismatch("light_on", got.light_on, want.light_on);
            if (got.level !== want.level)
                report_mismatch("level", got.level, want.level);
            if (got.level_written !== want.level_written)
                report_mismatch("level_written", got.level_written, want.level_written);
            if (got.ramping !== want.ramping)
                report_mismatch("ramping", got.ramping, want.ramping);
        endtask
    endclass

    logic clk;
    logic rst_n;
    logic cfg_we;
    logic [tdc_pkg::CFG_IDX_BITS-1:0]  cfg_index;
    logic [tdc_pkg::CFG_DATA_BITS-1:0] cfg_data;

    tdc_event_if  ev_ch();
    tdc_result_if res_ch();

    touch_dimmer_controller_top dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .event_ch  (ev_ch),
        .result_ch (res_ch),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    dimmer_scoreboard sb;
    bit src_idle;
    bit sink_idle;
    bit hold_req;
    int n_holds;
    int n_settings;
    int unsigned cycle_count;

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycle_count = cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles", cycle_count);
            $display("[touch_dimmer_controller_top] ERROR");
            $finish;
        end
    end

    // item and result monitor; inputs first so a same-edge result finds its entry
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (ev_ch.valid && ev_ch.ready)
                sb.predict_item(ev_ch.command, ev_ch.key_pressed,
                                ev_ch.key_released, ev_ch.key_long_press);
            if (res_ch.valid && res_ch.ready)
                sb.check_result('{res_ch.light_on, res_ch.level,
                                  res_ch.level_written, res_ch.ramping});
        end
    end

    // result side: random stall bursts plus one long hold-off on request
    initial
    begin
        int stall_left;
        stall_left = 0;
        res_ch.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_req)
            begin
                hold_req = 1'b0;
                stall_left = HOLD_CYCLES;
                n_holds++;
            end
            if (stall_left > 0)
            begin
                stall_left--;
                res_ch.ready <= 1'b0;
            end
            else if (sink_idle && $urandom_range(0, 6) == 0)
            begin
                stall_left = $urandom_range(1, 19) - 1;
                res_ch.ready <= 1'b0;
            end
            else
                res_ch.ready <= 1'b1;
        end
    end

    task send_item(input logic cmd, input logic kp, input logic kr, input logic kl);
        int gap_len;
        if (src_idle && $urandom_range(0, 5) == 0)
        begin
            gap_len = $urandom_range(1, 19);
            ev_ch.valid <= 1'b0;
            repeat (gap_len) @(posedge clk);
        end
        ev_ch.valid <= 1'b1;
        ev_ch.command <= cmd;
        ev_ch.key_pressed <= kp;
        ev_ch.key_released <= kr;
        ev_ch.key_long_press <= kl;
        @(posedge clk);
        while (!ev_ch.ready)
            @(posedge clk);
    endtask

    task wait_drained();
        ev_ch.valid <= 1'b0;
        @(posedge clk);
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // block must be idle; writes all four registers on consecutive edges
    task apply_settings(input logic [tdc_pkg::LONG_GAP_BITS-1:0] gap_lim,
                        input logic [tdc_pkg::STEP_BITS-1:0] step,
                        input logic [tdc_pkg::LIMIT_BITS-1:0] upper,
                        input logic [tdc_pkg::LIMIT_BITS-1:0] rmax);
        logic [tdc_pkg::CFG_IDX_BITS-1:0]  idxs [4];
        logic [tdc_pkg::CFG_DATA_BITS-1:0] vals [4];
        idxs[0] = tdc_pkg::REG_LONG_GAP;
        idxs[1] = tdc_pkg::REG_DIM_STEP;
        idxs[2] = tdc_pkg::REG_UPPER_LIMIT;
        idxs[3] = tdc_pkg::REG_RAMP_MAX;
        vals[0] = tdc_pkg::CFG_DATA_BITS'(gap_lim);
        vals[1] = tdc_pkg::CFG_DATA_BITS'(step);
        vals[2] = tdc_pkg::CFG_DATA_BITS'(upper);
        vals[3] = tdc_pkg::CFG_DATA_BITS'(rmax);
        for (int i = 0; i < 4; i++)
        begin
            cfg_we <= 1'b1;
            cfg_index <= idxs[i];
            cfg_data <= vals[i];
            sb.set_reg(idxs[i], vals[i]);
            @(posedge clk);
        end
        cfg_we <= 1'b0;
        n_settings++;
    endtask

    // mostly tick runs and short key sessions, some noise items
    task random_items(input int n);
        int sent;
        int pick;
        int run_len;
        sent = 0;
        while (sent < n)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 30)
            begin
                run_len = ($urandom_range(0, 9) == 0) ? $urandom_range(30, 80)
                                                      : $urandom_range(1, 6);
                repeat (run_len) send_item(tdc_pkg::CMD_TICK, 1'b0, 1'b0, 1'b0);
                sent += run_len;
            end
            else if (pick < 90)
            begin
                run_len = $urandom_range(1, 6);
                repeat (run_len)
                    send_item(tdc_pkg::CMD_KEY, $urandom_range(0, 3) == 0,
                              $urandom_range(0, 2) == 0, $urandom_range(0, 1) == 1);
                sent += run_len;
            end
            else
            begin
                send_item($urandom_range(0, 1) == 1, $urandom_range(0, 1) == 1,
                          $urandom_range(0, 1) == 1, $urandom_range(0, 1) == 1);
                sent++;
            end
        end
    endtask

    initial
    begin
        sb = new();
        src_idle = 1'b0;
        sink_idle = 1'b0;
        hold_req = 1'b0;
        n_holds = 0;
        n_settings = 0;
        cycle_count = 0;
        rst_n <= 1'b0;
        cfg_we <= 1'b0;
        cfg_index <= '0;
        cfg_data <= '0;
        ev_ch.valid <= 1'b0;
        ev_ch.command <= tdc_pkg::CMD_TICK;
        ev_ch.key_pressed <= 1'b0;
        ev_ch.key_released <= 1'b0;
        ev_ch.key_long_press <= 1'b0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset settings: ignored tick flags, ramp entry, ramp ignores long press,
        // step down below dim_step, release while off, all flags at once
        src_idle = 1'b1;
        sink_idle = 1'b1;
        send_item(tdc_pkg::CMD_TICK, 1'b0, 1'b0, 1'b0);
        send_item(tdc_pkg::CMD_TICK, 1'b1, 1'b1, 1'b1);
        send_item(tdc_pkg::CMD_KEY,  1'b0, 1'b0, 1'b0);
        send_item(tdc_pkg::CMD_KEY,  1'b0, 1'b0, 1'b1);
        send_item(tdc_pkg::CMD_TICK, 1'b0, 1'b0, 1'b0);
        send_item(tdc_pkg::CMD_TICK, 1'b0, 1'b0, 1'b0);
        send_item(tdc_pkg::CMD_KEY,  1'b0, 1'b0, 1'b1);
        send_item(tdc_pkg::CMD_KEY,  1'b1, 1'b0, 1'b0);
        send_item(tdc_pkg::CMD_KEY,  1'b0, 1'b0, 1'b1);
        send_item(tdc_pkg::CMD_KEY,  1'b0, 1'b1, 1'b0);
        send_item(tdc_pkg::CMD_KEY,  1'b0, 1'b0, 1'b1);
        send_item(tdc_pkg::CMD_KEY,  1'b1, 1'b0, 1'b0);
        send_item(tdc_pkg::CMD_KEY,  1'b0, 1'b1, 1'b0);
        send_item(tdc_pkg::CMD_KEY,  1'b1, 1'b0, 1'b0);
        send_item(tdc_pkg::CMD_KEY,  1'b1, 1'b1, 1'b1);
        send_item(tdc_pkg::CMD_KEY,  1'b1, 1'b0, 1'b1);
        wait_drained();

        // zero gap limit forces down after any tick; ramp saturates at 3
        apply_settings(16'd0, 8'd255, 12'd4095, 12'd3);
        send_item(tdc_pkg::CMD_KEY,  1'b1, 1'b0, 1'b0);
        send_item(tdc_pkg::CMD_KEY,  1'b0, 1'b0, 1'b1);
        repeat (5) send_item(tdc_pkg::CMD_TICK, 1'b0, 1'b0, 1'b0);
        send_item(tdc_pkg::CMD_KEY,  1'b1, 1'b0, 1'b0);
        send_item(tdc_pkg::CMD_KEY,  1'b0, 1'b1, 1'b0);
        send_item(tdc_pkg::CMD_KEY,  1'b0, 1'b0, 1'b1);
        send_item(tdc_pkg::CMD_KEY,  1'b0, 1'b1, 1'b1);
        wait_drained();

        // ramp to its ceiling, forced-down step after a long gap, step-up overflow
        src_idle = 1'b0;
        sink_idle = 1'b0;
        apply_settings(16'd80, 8'd255, 12'd4095, 12'd60);
        while (sb.mode != tdc_pkg::MODE_OFF)
        begin
            send_item(tdc_pkg::CMD_KEY, 1'b1, 1'b0, 1'b0);
            wait_drained();
        end
        send_item(tdc_pkg::CMD_KEY, 1'b0, 1'b0, 1'b1);
        repeat (100) send_item(tdc_pkg::CMD_TICK, 1'b0, 1'b0, 1'b0);
        send_item(tdc_pkg::CMD_KEY, 1'b1, 1'b0, 1'b0);
        wait_drained();
        if (sb.dim_down)
            send_item(tdc_pkg::CMD_KEY, 1'b0, 1'b1, 1'b0);
        send_item(tdc_pkg::CMD_KEY, 1'b0, 1'b0, 1'b1);
        send_item(tdc_pkg::CMD_KEY, 1'b0, 1'b1, 1'b0);
        repeat (17) send_item(tdc_pkg::CMD_KEY, 1'b0, 1'b0, 1'b1);
        wait_drained();

        src_idle = 1'b1;
        sink_idle = 1'b1;
        apply_settings(16'd0, 8'd1, 12'd4095, 12'd4095);
        random_items(230);
        wait_drained();

        // result side held off long enough to back up the event channel
        apply_settings(16'd65535, 8'd255, 12'd0, 12'd0);
        hold_req = 1'b1;
        random_items(230);
        wait_drained();

        // dim_step of zero makes long-press steps leave the level alone
        apply_settings(16'($urandom_range(0, 65535)), 8'd0,
                       12'($urandom_range(0, 4095)), 12'($urandom_range(0, 4095)));
        random_items(230);
        wait_drained();

        apply_settings(16'($urandom_range(0, 100)), 8'($urandom_range(1, 255)),
                       12'($urandom_range(0, 4095)), 12'($urandom_range(0, 4095)));
        random_items(230);
        wait_drained();

        src_idle = 1'b0;
        sink_idle = 1'b0;
        apply_settings(tdc_pkg::LONG_GAP_RESET, tdc_pkg::DIM_STEP_RESET,
                       tdc_pkg::UPPER_LIMIT_RESET, tdc_pkg::RAMP_MAX_RESET);
        random_items(230);
        wait_drained();

        if (sb.pending() != 0)
            sb.report_mismatch("results never arrived", 0, sb.pending());

        $display("covered %0d items, %0d results, %0d register settings, %0d long hold-offs",
                 sb.n_items, sb.n_results, n_settings, n_holds);
        $display("ramp ticks %0d, long-press steps %0d, forced-down steps %0d, mismatches %0d",
                 sb.n_ramp_ticks, sb.n_steps, sb.n_forced, sb.n_errors);
        if (sb.n_errors == 0)
            $display("[touch_dimmer_controller_top] OK");
        else
            $display("[touch_dimmer_controller_top] ERROR");
        $finish;
    end

endmodule
